// ----- src/pmi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, register codes and storage kind codes for the packed matrix
// index to offset unit.
// ----------------------------------------------------------------------------
package pmi_pkg;

    // Largest matrix dimension and band width a register can hold
    localparam int MAX_DIM = 4096;

    localparam int IDX_W    = 12;
    localparam int DIM_W    = 13;
    localparam int KIND_W   = 3;
    localparam int OFFSET_W = 24;
    localparam int COUNT_W  = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W    = 30;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [SUM_W-1:0]    sum_t;

    // Storage kinds
    localparam kind_t KIND_FULL  = 3'd0;
    localparam kind_t KIND_UPPER = 3'd1;
    localparam kind_t KIND_LOWER = 3'd2;
    localparam kind_t KIND_BAND  = 3'd3;
    localparam kind_t KIND_TRI   = 3'd4;
    localparam kind_t KIND_DIAG  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STORAGE_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAJOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BAND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BAND   = 3'd5;

    localparam sum_t COUNT_SAT = sum_t'((64'd1 << COUNT_W) - 64'd1);

    typedef struct packed {
        kind_t storage_kind;
        logic  row_major;
        dim_t  row_count;
        dim_t  col_count;
        dim_t  lower_band;
        dim_t  upper_band;
    } cfg_t;

    typedef struct packed {
        logic off_valid;
        logic is_defined;
        logic is_unique;
        logic cfg_bad;
    } flags_t;

    // Multiplier operands and linear terms, after the first stage.
    // Offset = lin_off + p0 + p1/2 - p2/2 - p3/2
    // Count  = lin_cnt + q0 + q1/2 - q2/2 - q3/2
    typedef struct packed {
        logic [13:0] x0;
        logic [12:0] y0;
        logic [12:0] x1;
        logic [14:0] y1;   // two's complement
        logic [12:0] x2;
        logic [13:0] y2;
        logic [12:0] x3;
        logic [12:0] y3;
        logic [13:0] u0;
        logic [12:0] v0;
        logic [12:0] u1;
        logic [12:0] v1;
        logic [12:0] u2;
        logic [12:0] v2;
        logic [12:0] u3;
        logic [12:0] v3;
        logic [13:0] lin_off;
        logic [15:0] lin_cnt;  // two's complement
        flags_t      flags;
    } opnd_t;

    typedef struct packed {
        logic [26:0] p0;
        logic [28:0] p1;   // two's complement
        logic [26:0] p2;
        logic [25:0] p3;
        logic [26:0] q0;
        logic [25:0] q1;
        logic [25:0] q2;
        logic [25:0] q3;
        logic [13:0] lin_off;
        logic [15:0] lin_cnt;
        flags_t      flags;
    } prod_t;

    typedef struct packed {
        sum_t   off_sum;
        sum_t   cnt_sum;
        flags_t flags;
    } acc_t;

    typedef struct packed {
        offset_t offset;
        logic    offset_valid;
        logic    is_defined;
        logic    is_unique;
        count_t  element_count;
        logic    config_bad;
    } res_t;

endpackage
`default_nettype wire

// ----- src/pmi_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_stream_if
// Valid/ready channels for index requests and offset results.
// ----------------------------------------------------------------------------
interface pmi_in_if;
    import pmi_pkg::*;

    logic valid;
    logic ready;
    idx_t row_index;
    idx_t col_index;
    logic transposed;

    modport source (output valid, output row_index, output col_index,
                    output transposed, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input transposed, output ready);
endinterface

interface pmi_out_if;
    import pmi_pkg::*;

    logic    valid;
    logic    ready;
    offset_t offset;
    logic    offset_valid;
    logic    is_defined;
    logic    is_unique;
    count_t  element_count;
    logic    config_bad;

    modport source (output valid, output offset, output offset_valid,
                    output is_defined, output is_unique, output element_count,
                    output config_bad, input ready);
    modport sink   (input valid, input offset, input offset_valid,
                    input is_defined, input is_unique, input element_count,
                    input config_bad, output ready);
endinterface
`default_nettype wire

// ----- src/pmi_operand_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_operand_stage
// First stage: swap for transpose, decode the storage kind, check bounds and
// pick the multiplier operands and linear terms for offset and count.
// ----------------------------------------------------------------------------
module pmi_operand_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pmi_pkg::cfg_t cfg,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire pmi_pkg::idx_t row_index,
    input  wire pmi_pkg::idx_t col_index,
    input  wire logic          transposed,
    output logic               down_valid,
    input  wire logic          down_ready,
    output pmi_pkg::opnd_t     down_data
);
    import pmi_pkg::*;

    logic  valid_reg;
    opnd_t data_reg;
    opnd_t data_next;

    idx_t        r;
    idx_t        c;
    idx_t        mn;
    idx_t        mx;
    dim_t        rc;
    dim_t        cc;
    dim_t        dim_min;
    logic [13:0] width_sum;
    logic        band_bad;

    // band terms in the packing orientation: primary, secondary, bands, dim
    idx_t        bp;
    idx_t        bs;
    dim_t        bka;
    dim_t        bkb;
    dim_t        bdim;
    logic [13:0] bt1;
    logic [14:0] bt2;
    logic        band_in;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        r  = transposed ? col_index : row_index;
        c  = transposed ? row_index : col_index;
        mn = (r < c) ? r : c;
        mx = (r < c) ? c : r;
        rc = cfg.row_count;
        cc = cfg.col_count;
        dim_min   = (cc < rc) ? cc : rc;
        width_sum = {1'b0, cfg.lower_band} + {1'b0, cfg.upper_band};
        band_bad  = (rc != cc) || (width_sum > {1'b0, rc});

        // orient the band formula by packing order
        if (cfg.row_major)
        begin
            bp   = r;
            bs   = c;
            bka  = cfg.lower_band;
            bkb  = cfg.upper_band;
            bdim = rc;
        end
        else
        begin
            bp   = c;
            bs   = r;
            bka  = cfg.upper_band;
            bkb  = cfg.lower_band;
            bdim = cc;
        end
        bt1 = {1'b0, bka} - {2'b0, bp} - 14'd1;
        bt2 = {3'b0, bp} - {2'b0, bdim} + {2'b0, bkb};
        band_in = (({2'b0, bs} + {1'b0, bka}) >= {2'b0, bp})
               && ({2'b0, bs} <= ({2'b0, bp} + {1'b0, bkb}));

        data_next = '0;
        case (cfg.storage_kind)
            KIND_FULL:
            begin
                data_next.flags.off_valid  = 1'b1;
                data_next.flags.is_defined = 1'b1;
                data_next.flags.is_unique  = 1'b1;
                if (cfg.row_major)
                begin
                    data_next.x0      = 14'(r);
                    data_next.y0      = cc;
                    data_next.lin_off = 14'(c);
                end
                else
                begin
                    data_next.x0      = 14'(c);
                    data_next.y0      = rc;
                    data_next.lin_off = 14'(r);
                end
                data_next.u0 = 14'(rc);
                data_next.v0 = cc;
            end
            KIND_UPPER:
            begin
                data_next.flags.off_valid  = 1'b1;
                data_next.flags.is_defined = 1'b1;
                data_next.flags.is_unique  = (r <= c);
                if (cfg.row_major)
                begin
                    // (b - a) + a(2C - a + 1)/2
                    data_next.x1      = 13'(mn);
                    data_next.y1      = 15'({cc, 1'b0}) - 15'(mn) + 15'd1;
                    data_next.lin_off = 14'(mx) - 14'(mn);
                end
                else if (13'(mx) < rc)
                begin
                    data_next.x1      = 13'(mx);
                    data_next.y1      = 15'(mx) + 15'd1;
                    data_next.lin_off = 14'(mn);
                end
                else
                begin
                    data_next.x1      = rc;
                    data_next.y1      = 15'(rc) + 15'd1;
                    data_next.x0      = 14'(13'(mx) - rc);
                    data_next.y0      = rc;
                    data_next.lin_off = 14'(mn);
                end
                if (cc <= rc)
                begin
                    data_next.u1 = cc;
                    data_next.v1 = cc + 13'd1;
                end
                else
                begin
                    data_next.u1 = rc;
                    data_next.v1 = rc + 13'd1;
                    data_next.u0 = 14'(cc - rc);
                    data_next.v0 = rc;
                end
            end
            KIND_LOWER:
            begin
                data_next.flags.off_valid  = 1'b1;
                data_next.flags.is_defined = 1'b1;
                data_next.flags.is_unique  = (r >= c);
                if (!cfg.row_major)
                begin
                    // (a - b) + b(2R - b + 1)/2
                    data_next.x1      = 13'(mn);
                    data_next.y1      = 15'({rc, 1'b0}) - 15'(mn) + 15'd1;
                    data_next.lin_off = 14'(mx) - 14'(mn);
                end
                else if (13'(mx) < cc)
                begin
                    data_next.x1      = 13'(mx);
                    data_next.y1      = 15'(mx) + 15'd1;
                    data_next.lin_off = 14'(mn);
                end
                else
                begin
                    data_next.x1      = cc;
                    data_next.y1      = 15'(cc) + 15'd1;
                    data_next.x0      = 14'(13'(mx) - cc);
                    data_next.y0      = cc;
                    data_next.lin_off = 14'(mn);
                end
                if (cc <= rc)
                begin
                    data_next.u1 = cc;
                    data_next.v1 = cc + 13'd1;
                    data_next.u0 = 14'(rc - cc);
                    data_next.v0 = cc;
                end
                else
                begin
                    data_next.u1 = rc;
                    data_next.v1 = rc + 13'd1;
                end
            end
            KIND_BAND:
            begin
                if (band_bad)
                begin
                    data_next.flags.cfg_bad = 1'b1;
                end
                else
                begin
                    data_next.flags.off_valid  = band_in;
                    data_next.flags.is_defined = band_in;
                    data_next.flags.is_unique  = band_in;
                    // w*p + s + ka - T(ka) + T(ka - p - 1) - T(p - dim + kb)
                    data_next.x0      = width_sum;
                    data_next.y0      = 13'(bp);
                    data_next.lin_off = 14'(bs) + 14'(bka);
                    if (!bt1[13] && (bt1 != 14'd0))
                    begin
                        data_next.x1 = bt1[12:0];
                        data_next.y1 = 15'(bt1[12:0]) + 15'd1;
                    end
                    if (!bt2[14] && (bt2 != 15'd0))
                    begin
                        data_next.x2 = bt2[12:0];
                        data_next.y2 = 14'(bt2[12:0]) + 14'd1;
                    end
                    data_next.x3 = bka;
                    data_next.y3 = bka + 13'd1;
                    // (w + 1)R - T(k1) - T(k2)
                    data_next.u0 = width_sum + 14'd1;
                    data_next.v0 = rc;
                    data_next.u2 = cfg.lower_band;
                    data_next.v2 = cfg.lower_band + 13'd1;
                    data_next.u3 = cfg.upper_band;
                    data_next.v3 = cfg.upper_band + 13'd1;
                end
            end
            KIND_TRI:
            begin
                data_next.flags.off_valid  = (r == c) || ({1'b0, r} == {1'b0, c} + 13'd1)
                                          || ({1'b0, c} == {1'b0, r} + 13'd1);
                data_next.flags.is_defined = data_next.flags.off_valid;
                data_next.flags.is_unique  = data_next.flags.off_valid;
                if (cfg.row_major)
                begin
                    data_next.lin_off = 14'({r, 1'b0}) + 14'(c);
                end
                else
                begin
                    data_next.lin_off = 14'({c, 1'b0}) + 14'(r);
                end
                if (rc == cc)
                begin
                    data_next.lin_cnt = 16'(cc) + 16'({cc, 1'b0}) - 16'd2;
                end
                else
                begin
                    data_next.lin_cnt = 16'(dim_min) + 16'({dim_min, 1'b0}) - 16'd1;
                end
            end
            KIND_DIAG:
            begin
                data_next.flags.off_valid  = (r == c);
                data_next.flags.is_defined = (r == c);
                data_next.flags.is_unique  = (r == c);
                data_next.lin_off          = 14'(r);
                data_next.lin_cnt          = 16'(dim_min);
            end
            default:
            begin
                data_next.flags.cfg_bad = 1'b1;
            end
        endcase
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Load the operands on a transfer
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/pmi_product_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_product_stage
// Second stage: eight parallel multipliers, one per offset or count term.
// ----------------------------------------------------------------------------
module pmi_product_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire pmi_pkg::opnd_t up_data,
    output logic                down_valid,
    input  wire logic           down_ready,
    output pmi_pkg::prod_t      down_data
);
    import pmi_pkg::*;

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // Multiply each operand pair
    always_comb
    begin
        data_next.p0 = 27'(up_data.x0) * 27'(up_data.y0);
        // extend both operands before the signed multiply
        data_next.p1 = 29'($signed({{15{1'b0}}, up_data.x1})
                         * $signed({{14{up_data.y1[14]}}, up_data.y1}));
        data_next.p2 = 27'(up_data.x2) * 27'(up_data.y2);
        data_next.p3 = 26'(up_data.x3) * 26'(up_data.y3);
        data_next.q0 = 27'(up_data.u0) * 27'(up_data.v0);
        data_next.q1 = 26'(up_data.u1) * 26'(up_data.v1);
        data_next.q2 = 26'(up_data.u2) * 26'(up_data.v2);
        data_next.q3 = 26'(up_data.u3) * 26'(up_data.v3);
        data_next.lin_off = up_data.lin_off;
        data_next.lin_cnt = up_data.lin_cnt;
        data_next.flags   = up_data.flags;
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Load the products on a transfer
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/pmi_sum_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_sum_stage
// Third stage: combine products and linear terms into raw offset and count.
// ----------------------------------------------------------------------------
module pmi_sum_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire pmi_pkg::prod_t up_data,
    output logic                down_valid,
    input  wire logic           down_ready,
    output pmi_pkg::acc_t       down_data
);
    import pmi_pkg::*;

    logic valid_reg;
    acc_t data_reg;
    acc_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // Halve the triangular products (always even) and sum
    always_comb
    begin
        data_next.off_sum = {16'd0, up_data.lin_off}
                          + {3'd0, up_data.p0}
                          + {{2{up_data.p1[28]}}, up_data.p1[28:1]}
                          - {4'd0, up_data.p2[26:1]}
                          - {5'd0, up_data.p3[25:1]};
        data_next.cnt_sum = {{14{up_data.lin_cnt[15]}}, up_data.lin_cnt}
                          + {3'd0, up_data.q0}
                          + {5'd0, up_data.q1[25:1]}
                          - {5'd0, up_data.q2[25:1]}
                          - {5'd0, up_data.q3[25:1]};
        data_next.flags   = up_data.flags;
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Load the sums on a transfer
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/pmi_output_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_output_stage
// Last stage: wrap the offset, clamp the count and hold the result until it
// is taken.
// ----------------------------------------------------------------------------
module pmi_output_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire pmi_pkg::acc_t up_data,
    output logic               down_valid,
    input  wire logic          down_ready,
    output pmi_pkg::res_t      down_data
);
    import pmi_pkg::*;

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        // drop the offset where the element is not stored
        data_next.offset       = up_data.flags.off_valid ? up_data.off_sum[OFFSET_W-1:0]
                                                         : '0;
        data_next.offset_valid = up_data.flags.off_valid;
        data_next.is_defined   = up_data.flags.is_defined;
        data_next.is_unique    = up_data.flags.is_unique;
        data_next.config_bad   = up_data.flags.cfg_bad;
        // clamp the count to the range of the port
        if (up_data.cnt_sum[SUM_W-1])
        begin
            data_next.element_count = '0;
        end
        else if (up_data.cnt_sum > COUNT_SAT)
        begin
            data_next.element_count = COUNT_SAT[COUNT_W-1:0];
        end
        else
        begin
            data_next.element_count = up_data.cnt_sum[COUNT_W-1:0];
        end
    end

    // Advance the output valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/packed_matrix_index_to_offset_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_matrix_index_to_offset_unit
// Maps a (row, column) index to its offset in full, triangular, band,
// tridiagonal or diagonal packed storage, with status bits and element count.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      row_index, col_index, transposed
//  out_ch   out  valid / ready      offset, offset_valid, is_defined,
//                                   is_unique, element_count, config_bad
//  cfg      in   cfg_we             cfg_index, cfg_data
//
//  Four register stages (operands, multipliers, sums, output): a request's
//  result passes through them in that order to out_ch; one request per cycle
//  while out_ch takes its results.
//  Each stage fills when empty or when the next stage advances, so bubbles
//  close up and a stall at out_ch holds every item in place.
//  Reset clears the stage valid bits and sets the registers to full storage,
//  row-major, one by one, no bands. Dimension writes above 4096 saturate.
//
module packed_matrix_index_to_offset_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pmi_in_if.sink                            in_ch,
    pmi_out_if.source                         out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [pmi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pmi_pkg::*;

    cfg_t  cfg_reg;
    dim_t  cfg_dim;

    logic  s1_valid;
    logic  s1_ready;
    opnd_t s1_data;
    logic  s2_valid;
    logic  s2_ready;
    prod_t s2_data;
    logic  s3_valid;
    logic  s3_ready;
    acc_t  s3_data;
    res_t  res;

    // Saturate dimension writes
    assign cfg_dim = (cfg_data > dim_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : cfg_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.storage_kind <= KIND_FULL;
            cfg_reg.row_major    <= 1'b1;
            cfg_reg.row_count    <= dim_t'(1);
            cfg_reg.col_count    <= dim_t'(1);
            cfg_reg.lower_band   <= '0;
            cfg_reg.upper_band   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STORAGE_KIND: cfg_reg.storage_kind <= cfg_data[KIND_W-1:0];
                REG_ROW_MAJOR:    cfg_reg.row_major    <= cfg_data[0];
                REG_ROW_COUNT:    cfg_reg.row_count    <= cfg_dim;
                REG_COL_COUNT:    cfg_reg.col_count    <= cfg_dim;
                REG_LOWER_BAND:   cfg_reg.lower_band   <= cfg_dim;
                REG_UPPER_BAND:   cfg_reg.upper_band   <= cfg_dim;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pmi_operand_stage u_operand (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (in_ch.valid),
        .up_ready   (in_ch.ready),
        .row_index  (in_ch.row_index),
        .col_index  (in_ch.col_index),
        .transposed (in_ch.transposed),
        .down_valid (s1_valid),
        .down_ready (s1_ready),
        .down_data  (s1_data)
    );

    pmi_product_stage u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .up_data    (s1_data),
        .down_valid (s2_valid),
        .down_ready (s2_ready),
        .down_data  (s2_data)
    );

    pmi_sum_stage u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s2_valid),
        .up_ready   (s2_ready),
        .up_data    (s2_data),
        .down_valid (s3_valid),
        .down_ready (s3_ready),
        .down_data  (s3_data)
    );

    pmi_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s3_valid),
        .up_ready   (s3_ready),
        .up_data    (s3_data),
        .down_valid (out_ch.valid),
        .down_ready (out_ch.ready),
        .down_data  (res)
    );

    // Drive the result channel
    assign out_ch.offset        = res.offset;
    assign out_ch.offset_valid  = res.offset_valid;
    assign out_ch.is_defined    = res.is_defined;
    assign out_ch.is_unique     = res.is_unique;
    assign out_ch.element_count = res.element_count;
    assign out_ch.config_bad    = res.config_bad;

endmodule
`default_nettype wire
